### sv/kvt_pkg.sv
package kvt_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned CAP_W = 9;
  localparam int unsigned STATUS_W = 3;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Request operations.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // One table entry as it sits in the store.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kvt_entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_RESP
  } kvt_state_t;

endpackage

### sv/kvt_store.sv
module kvt_store import kvt_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = 8
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  kvt_entry_t      wr_entry,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output kvt_entry_t      rd_entry
);

  kvt_entry_t mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

### sv/key_value_table_insert_lookup.sv
// The scan reads one stored entry per cycle and compares it the next cycle; an insert or an
// update then passes the write state, and the response state loads the output register.
// One request at a time: the next is taken the cycle after a result loads; a stalled result
// holds the block in its response state.
// Synchronous active-low reset empties the table and sets capacity to 256; the store keeps data.
module key_value_table_insert_lookup import kvt_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_W-1:0]    out_found_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_capacity
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  kvt_state_t state_r, state_nxt;

  logic [CAP_W-1:0]    capacity_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       cmp_r, cmp_nxt;
  logic                pend_r, pend_nxt;
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    value_r;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic                grow_r, grow_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]    result_r, result_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_value_r;

  logic       accept;
  logic       pend_match;
  logic       addr_more;
  logic       scan_done;
  logic       need_write;
  logic       table_full;
  logic       out_free;
  logic       rd_en;
  logic       wr_en;
  kvt_entry_t rd_entry;
  kvt_entry_t wr_entry;

  // Shared entry store.
  kvt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (idx_r),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (addr_r[AW-1:0]),
    .rd_entry (rd_entry)
  );

  // Scan progress, the outcome of the search, the handshake terms and the entry to write.
  always_comb begin
    accept     = in_valid && !in_stall;
    pend_match = pend_r && (rd_entry.key == key_r);
    addr_more  = addr_r < count_r;
    scan_done  = pend_match || !addr_more;
    table_full = (32'(count_r) >= 32'(capacity_r)) || (32'(count_r) >= 32'(DEPTH));
    need_write = (op_r == OP_INSERT) && (pend_match || !table_full);
    out_free   = !out_valid_r || !out_stall;
    wr_entry.key   = key_r;
    wr_entry.value = value_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = need_write ? S_WRITE : S_RESP;
        end
      end
      S_WRITE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake and store controls.
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_SCAN: begin
        rd_en = !scan_done;
      end
      S_WRITE: begin
        wr_en = 1'b1;
      end
      S_RESP: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    addr_nxt      = addr_r;
    cmp_nxt       = cmp_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    grow_nxt      = grow_r;
    status_nxt    = status_r;
    result_nxt    = result_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        addr_nxt = '0;
        pend_nxt = 1'b0;
      end
      S_SCAN: begin
        if (scan_done) begin
          pend_nxt   = 1'b0;
          grow_nxt   = 1'b0;
          result_nxt = '0;
          if (pend_match) begin
            idx_nxt = cmp_r;
            if (op_r == OP_INSERT) begin
              status_nxt = ST_UPDATED;
            end else begin
              status_nxt = ST_FOUND;
              result_nxt = rd_entry.value;
            end
          end else if (op_r == OP_LOOKUP) begin
            status_nxt = ST_NOTFOUND;
          end else if (table_full) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt = ST_INSERTED;
            idx_nxt    = count_r[AW-1:0];
            grow_nxt   = 1'b1;
          end
        end else begin
          // Issue the next read and compare its data in the next cycle.
          pend_nxt = 1'b1;
          cmp_nxt  = addr_r[AW-1:0];
          addr_nxt = addr_r + CW'(1);
        end
      end
      S_WRITE: begin
        if (grow_r) begin
          count_nxt = count_r + CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      capacity_r  <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    cmp_r    <= cmp_nxt;
    idx_r    <= idx_nxt;
    grow_r   <= grow_nxt;
    status_r <= status_nxt;
    result_r <= result_nxt;
    if (accept) begin
      op_r    <= in_opcode;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (state_r == S_RESP && out_free) begin
      out_status_r <= status_r;
      out_value_r  <= result_r;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule

### tb/key_value_table_checker.sv
module key_value_table_checker import kvt_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_opcode,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [VAL_W-1:0]    in_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [VAL_W-1:0]    out_found_value,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_capacity,
  input  logic                run_done,
  output int                  mismatch_count,
  output int                  results_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // One answer of the table, as the result channel carries it.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
  } table_answer_t;

  // Shadow copy of the table contents and its capacity register.
  logic [KEY_W-1:0] shadow_keys [DEPTH];
  logic [VAL_W-1:0] shadow_values [DEPTH];
  int unsigned      shadow_count;
  logic [CAP_W-1:0] shadow_capacity;

  table_answer_t answers_due [$];
  table_answer_t oldest;
  bit            leftovers_reported;

  initial begin
    mismatch_count = 0;
    results_pending = 0;
    shadow_count = 0;
    shadow_capacity = CAP_RESET;
    leftovers_reported = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one request to the shadow table and returns the answer it should give.
  function automatic table_answer_t apply_request(input logic op,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] value);
    table_answer_t ans;
    int unsigned   limit;
    int unsigned   slot;
    bit            hit;
    ans.status = ST_NOTFOUND;
    ans.found_value = '0;
    limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    slot = shadow_count;
    hit = 1'b0;
    // Keys are unique, so the first match is the only one.
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_keys[i] == key) begin
        slot = i;
        hit = 1'b1;
      end
    end
    if (op == OP_INSERT) begin
      if (hit) begin
        shadow_values[slot] = value;
        ans.status = ST_UPDATED;
      end else if (shadow_count >= limit || shadow_count >= DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        shadow_keys[shadow_count] = key;
        shadow_values[shadow_count] = value;
        shadow_count++;
        ans.status = ST_INSERTED;
      end
    end else if (hit) begin
      ans.status = ST_FOUND;
      ans.found_value = shadow_values[slot];
    end
    return ans;
  endfunction

  // Everything is sampled at the rising edge, before any update of that edge lands.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      shadow_capacity = CAP_RESET;
      answers_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        shadow_capacity = cfg_capacity;
      end

      // An accepted request always produces exactly one answer.
      if (in_valid && !in_stall) begin
        answers_due.push_back(apply_request(in_opcode, in_key, in_value));
      end

      // Compare each accepted answer with the oldest one still owed.
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result status %0d with no request outstanding",
                                    out_status));
        end else begin
          oldest = answers_due.pop_front();
          if (out_status !== oldest.status) begin
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      out_status, oldest.status));
          end
          if (out_found_value !== oldest.found_value) begin
            report_mismatch($sformatf("found_value %h, predicted %h",
                                      out_found_value, oldest.found_value));
          end
        end
      end

      // At the end of the run any answer still owed is a failure.
      if (run_done && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        foreach (answers_due[i]) begin
          report_mismatch($sformatf("no result for status %0d, value %h",
                                    answers_due[i].status, answers_due[i].found_value));
        end
      end
    end
    results_pending <= answers_due.size();
  end

endmodule

### tb/key_value_table_insert_lookup_test.sv
module key_value_table_insert_lookup_test;

  timeunit 1ns;
  timeprecision 1ps;

  import kvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 256;
  // Long enough for the slowest request and then some.
  localparam int unsigned DRAIN_CYCLES = TABLE_DEPTH + 16;
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_opcode = OP_INSERT;
  logic [KEY_W-1:0]    in_key = '0;
  logic [VAL_W-1:0]    in_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0]    out_found_value;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_capacity = CAP_RESET;
  logic                run_done = 1'b0;
  logic                hold_toggle = 1'b0;

  int fail_count;
  int results_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Keys that have been offered for insertion, reused to hit stored entries.
  logic [KEY_W-1:0] offered_keys [$];

  key_value_table_insert_lookup #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity)
  );

  key_value_table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_capacity    (cfg_capacity),
    .run_done        (run_done),
    .mismatch_count  (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off whenever the toggle flips.
  initial begin : result_sink
    int  hold_left;
    bit  hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one request after a random gap and returns once it is accepted.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key <= key;
    in_value <= value;
    if (op == OP_INSERT) begin
      offered_keys.push_back(key);
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (results_pending != 0);
  endtask

  // The capacity is only changed with the table idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Extremes of the fields, both operations and the capacity corner cases.
  task automatic run_directed();
    logic [KEY_W-1:0] odd_key;
    odd_key = 64'h8000_0000_0000_0001;
    // Reset capacity, then a lookup that hits.
    send_request(OP_INSERT, '0, '1);
    send_request(OP_LOOKUP, '0, '0);
    // Zero capacity, already exceeded: new keys are refused, updates pass.
    in_valid <= 1'b0;
    write_capacity('0);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_INSERT, '0, 64'h5555_5555_5555_5555);
    send_request(OP_LOOKUP, '1, '0);
    // Small capacity filled up to its limit.
    in_valid <= 1'b0;
    write_capacity(9'd3);
    send_request(OP_INSERT, '1, '0);
    send_request(OP_INSERT, odd_key, 64'h0123_4567_89ab_cdef);
    send_request(OP_INSERT, 64'd1, 64'd1);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_LOOKUP, odd_key, '0);
    send_request(OP_LOOKUP, 64'd1, '0);
    // A lookup ignores its value field.
    send_request(OP_LOOKUP, '0, '1);
    // Capacity lowered below the count: no entry is dropped.
    in_valid <= 1'b0;
    write_capacity(9'd1);
    send_request(OP_INSERT, odd_key, '0);
    send_request(OP_INSERT, 64'h7fff_ffff_ffff_fffe, '1);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, odd_key, '0);
    in_valid <= 1'b0;
  endtask

  // One phase of random requests under a given capacity and idling mix.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle_pct,
                           input int stall_pct, input int count, input int insert_pct,
                           input int fresh_pct, input bit hold_off, input bit mid_pause);
    logic             op;
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold_off) begin
      hold_toggle <= ~hold_toggle;
    end
    for (int i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) begin
        in_valid <= 1'b0;
        wait_for_results();
      end
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
      if (offered_keys.size() == 0 || $urandom_range(99) < fresh_pct) begin
        key = random_word();
      end else begin
        key = offered_keys[$urandom_range(offered_keys.size() - 1)];
        // Now and then a near miss that differs from a stored key in one bit.
        if ($urandom_range(9) == 0) begin
          key = key ^ (64'd1 << $urandom_range(63));
        end
      end
      send_request(op, key, random_word());
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // The table only grows, so the capacity is kept small until the last phases.
    run_phase(9'd17, 0, 0, 220, 50, 30, 1'b0, 1'b0);
    run_phase(9'd40, 66, 0, 220, 50, 30, 1'b0, 1'b0);
    run_phase(9'd64, 0, 66, 220, 50, 30, 1'b1, 1'b0);
    run_phase(9'd5, 33, 33, 180, 50, 30, 1'b0, 1'b1);
    // Capacity above the depth: fill the whole store and run into its end.
    run_phase(9'd511, 33, 33, 350, 80, 75, 1'b0, 1'b0);
    run_phase(CAP_RESET, 0, 0, 60, 50, 20, 1'b0, 1'b0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
